// ===== design/radix_number_token_parser_defines.svh =====
// Assertion macros shared by the radix number token parser RTL.
`ifndef RADIX_NUMBER_TOKEN_PARSER_DEFINES_SVH
`define RADIX_NUMBER_TOKEN_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define RNTP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed by another one at the next clock edge.
`define RNTP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RNTP_ASSERT(label, clk, rst, prop, msg)
`define RNTP_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

// ===== design/rntp_pkg.sv =====
// Types, constants and helper functions of the radix number token parser.
package rntp_pkg;

   // Default widths of the accumulator and of the line counter.
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int LINE_BITS_DEFAULT  = 16;

   // Widths of the result fields on the stream interface.
   localparam int NUMBER_BITS = 32;
   localparam int INDEX_BITS  = 16;

   // Radix register: reset value and the range that takes effect.
   localparam logic [5:0] RADIX_RESET = 6'd10;
   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;

   // Register index of the radix on the configuration port.
   localparam logic RADIX_INDEX = 1'b0;

   // Characters the parser treats specially.
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] LETTER_BASE = 8'd10;

   // Tokeniser phase.
   typedef enum logic [1:0] {
      PHASE_SCAN   = 2'd0,
      PHASE_SIGN   = 2'd1,
      PHASE_DIGITS = 2'd2
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_NUMBER = 2'd1,
      STATUS_BAD_DIGIT = 2'd2,
      STATUS_END       = 2'd3
   } status_type;

   // One result as held in the output queue.
   typedef struct packed {
      logic [INDEX_BITS-1:0]  line_index;
      logic [NUMBER_BITS-1:0] number_value;
      status_type             status;
      logic                   last;
   } result_type;

   // Decoded digit of one character.
   typedef struct packed {
      logic       is_digit;
      logic [5:0] value;
   } digit_type;

   // Maps 0-9, a-z and A-Z to their digit values.
   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      logic [7:0] v;
      d.is_digit = 1'b1;
      v = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         v = c - CHAR_LOW_A + LETTER_BASE;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         v = c - CHAR_UP_A + LETTER_BASE;
      end else begin
         d.is_digit = 1'b0;
      end
      d.value = v[5:0];
      return d;
   endfunction

   // Clamps the configured radix into the supported range.
   function automatic logic [5:0] effective_radix(input logic [5:0] r);
      logic [5:0] e;
      e = r;
      if (r < RADIX_MIN) begin
         e = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         e = RADIX_MAX;
      end
      return e;
   endfunction

endpackage

// ===== design/radix_number_token_parser.sv =====
// Top level of the radix number token parser: tokeniser, result queue and register port.
//
// Parses a byte stream into signed integers written in a programmable radix (2 to 36,
// register 0 at byte address 0; values outside the range act as the nearest limit).
// Blanks and '#' or ';' comments are skipped, line ends are counted (CR LF once), and
// every number, lone sign, stray byte, bad digit and end of stream gives a result
// transaction carrying its status and the current line count. One byte is accepted per
// clock when the input is not stalled: it lands in an input register, is decoded there,
// and its results enter the result queue as the byte moves on, to be presented from the
// queue's registers. A byte gives at most two results, and these go through a four-entry
// result queue; the input stalls only while the queue has fewer than two free entries,
// so a stream of bytes with one result or none each runs at one byte per cycle, while
// bytes that give two results are limited by the result port to one result per cycle.
`include "radix_number_token_parser_defines.svh"

module radix_number_token_parser
   import rntp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int LINE_BITS  = LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] byte_in
   input  logic        req_tuser,    // [0] end_of_input
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [31:0] number_value, [47:32] line_index
   output logic [1:0]  rsp_tuser,    // [1:0] status
   output logic        rsp_tlast,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int VALUE_WIDE = (VALUE_BITS > NUMBER_BITS) ? VALUE_BITS : NUMBER_BITS;
   localparam int LINE_WIDE  = (LINE_BITS > INDEX_BITS) ? LINE_BITS : INDEX_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = PTR_BITS + 1;

   // Registers
   logic [5:0]            radix_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_eoi_ff;
   phase_type             phase_ff, phase_in;
   logic                  in_comment_ff, in_comment_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic                  negative_ff, negative_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   result_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Combinational signals
   logic                  req_fire;
   logic                  fire;
   logic                  pop;
   logic                  csr_write;
   logic [5:0]            radix_eff;
   digit_type             dig;
   logic [VALUE_BITS+5:0] product;
   logic [VALUE_BITS-1:0] signed_acc;
   logic [VALUE_WIDE-1:0] value_wide;
   logic [LINE_WIDE-1:0]  line_wide;
   logic [NUMBER_BITS-1:0] value_out;
   logic [INDEX_BITS-1:0] line_out;

   phase_type             sc_phase;
   logic                  sc_comment;
   logic                  sc_prev;
   logic                  sc_negative;
   logic [VALUE_BITS-1:0] sc_acc;
   logic [LINE_BITS-1:0]  sc_line;
   logic                  sc_valid;
   status_type            sc_status;

   logic                  r0_valid, r1_valid;
   result_type            r0, r1;
   logic [1:0]            push_count;

   // Register port: one register, writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == RADIX_INDEX);
   assign csr_prdata = (csr_paddr[2] == RADIX_INDEX) ? {26'd0, radix_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write) begin
         radix_ff <= csr_pwdata[5:0];
      end
   end

   // Input register: the next byte is taken whenever the held one moves on.
   assign fire        = in_valid_ff && (count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2));
   assign req_tready  = !in_valid_ff || fire;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
   end

   // Digit decode, multiply-add and the signed value of the number so far.
   assign radix_eff  = effective_radix(radix_ff);
   assign dig        = digit_of(in_byte_ff);
   assign product    = (VALUE_BITS + 6)'(acc_ff) * (VALUE_BITS + 6)'(radix_eff);
   assign signed_acc = negative_ff ? (~acc_ff + VALUE_BITS'(1)) : acc_ff;
   assign value_wide = VALUE_WIDE'(signed_acc);
   assign value_out  = value_wide[NUMBER_BITS-1:0];
   assign line_wide  = LINE_WIDE'(line_ff);
   assign line_out   = line_wide[INDEX_BITS-1:0];

   // Scanning between tokens: blanks, comments, line ends, signs, first digits and stray bytes.
   always_comb begin
      sc_phase    = PHASE_SCAN;
      sc_comment  = in_comment_ff;
      sc_prev     = (in_byte_ff == CHAR_CR);
      sc_negative = 1'b0;
      sc_acc      = '0;
      sc_line     = line_ff;
      sc_valid    = 1'b0;
      sc_status   = STATUS_NO_NUMBER;
      priority if (in_byte_ff == CHAR_CR) begin
         sc_line    = line_ff + LINE_BITS'(1);
         sc_comment = 1'b0;
      end else if (in_byte_ff == CHAR_LF) begin
         if (!prev_cr_ff) begin
            sc_line = line_ff + LINE_BITS'(1);
         end
         sc_comment = 1'b0;
      end else if (in_comment_ff || in_byte_ff == CHAR_SPACE || in_byte_ff == CHAR_TAB) begin
         // Skipped without effect.
         sc_comment = in_comment_ff;
      end else if (in_byte_ff == CHAR_HASH || in_byte_ff == CHAR_SEMI) begin
         sc_comment = 1'b1;
      end else if (in_byte_ff == CHAR_PLUS || in_byte_ff == CHAR_MINUS) begin
         sc_phase    = PHASE_SIGN;
         sc_negative = (in_byte_ff == CHAR_MINUS);
      end else if (!dig.is_digit) begin
         sc_valid  = 1'b1;
         sc_status = STATUS_NO_NUMBER;
      end else if (dig.value >= radix_eff) begin
         sc_valid  = 1'b1;
         sc_status = STATUS_BAD_DIGIT;
      end else begin
         sc_phase = PHASE_DIGITS;
         sc_acc   = VALUE_BITS'(dig.value);
      end
   end

   // Token state machine: next state and up to two results for the held byte.
   always_comb begin
      phase_in      = phase_ff;
      in_comment_in = in_comment_ff;
      prev_cr_in    = prev_cr_ff;
      negative_in   = negative_ff;
      acc_in        = acc_ff;
      line_in       = line_ff;
      r0_valid      = 1'b0;
      r1_valid      = 1'b0;
      r0            = '{line_index: line_out, number_value: '0,
                        status: STATUS_NO_NUMBER, last: 1'b0};
      r1            = r0;
      if (in_eoi_ff) begin
         // End of stream closes any token, then reports itself.
         unique case (phase_ff)
            PHASE_DIGITS: begin
               r0_valid        = 1'b1;
               r0.status       = STATUS_OK;
               r0.number_value = value_out;
               r1_valid        = 1'b1;
               r1.status       = STATUS_END;
            end
            PHASE_SIGN: begin
               r0_valid  = 1'b1;
               r0.status = STATUS_NO_NUMBER;
               r1_valid  = 1'b1;
               r1.status = STATUS_END;
            end
            default: begin
               r0_valid  = 1'b1;
               r0.status = STATUS_END;
            end
         endcase
         phase_in      = PHASE_SCAN;
         in_comment_in = 1'b0;
         prev_cr_in    = 1'b0;
         negative_in   = 1'b0;
         acc_in        = '0;
      end else if (phase_ff == PHASE_SIGN || phase_ff == PHASE_DIGITS) begin
         priority if (!dig.is_digit) begin
            // Terminator: close the token, then scan the same byte.
            r0_valid = 1'b1;
            if (phase_ff == PHASE_DIGITS) begin
               r0.status       = STATUS_OK;
               r0.number_value = value_out;
            end else begin
               r0.status = STATUS_NO_NUMBER;
            end
            r1_valid      = sc_valid;
            r1.status     = sc_status;
            phase_in      = sc_phase;
            in_comment_in = sc_comment;
            prev_cr_in    = sc_prev;
            negative_in   = sc_negative;
            acc_in        = sc_acc;
            line_in       = sc_line;
         end else if (dig.value >= radix_eff) begin
            r0_valid    = 1'b1;
            r0.status   = STATUS_BAD_DIGIT;
            phase_in    = PHASE_SCAN;
            negative_in = 1'b0;
            acc_in      = '0;
         end else begin
            if (phase_ff == PHASE_SIGN) begin
               acc_in = VALUE_BITS'(dig.value);
            end else begin
               acc_in = product[VALUE_BITS-1:0] + VALUE_BITS'(dig.value);
            end
            phase_in = PHASE_DIGITS;
         end
      end else begin
         r0_valid      = sc_valid;
         r0.status     = sc_status;
         phase_in      = sc_phase;
         in_comment_in = sc_comment;
         prev_cr_in    = sc_prev;
         negative_in   = sc_negative;
         acc_in        = sc_acc;
         line_in       = sc_line;
      end
      // The final result of the byte carries the last flag.
      if (r1_valid) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_SCAN;
         in_comment_ff <= 1'b0;
         prev_cr_ff    <= 1'b0;
         negative_ff   <= 1'b0;
         acc_ff        <= '0;
         line_ff       <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         in_comment_ff <= in_comment_in;
         prev_cr_ff    <= prev_cr_in;
         negative_ff   <= negative_in;
         acc_ff        <= acc_in;
         line_ff       <= line_in;
      end
   end

   // Result queue: up to two writes and one read per cycle.
   assign push_count = fire ? ({1'b0, r0_valid} + {1'b0, r1_valid}) : 2'd0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign wr_ptr_in  = wr_ptr_ff + PTR_BITS'(push_count);
   assign rd_ptr_in  = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in   = count_ff + COUNT_BITS'(push_count) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && r0_valid) begin
         queue_ff[wr_ptr_ff] <= r0;
      end
      if (fire && r1_valid) begin
         queue_ff[wr_ptr_ff + PTR_BITS'(1)] <= r1;
      end
   end

   // Result stream outputs from the head of the queue.
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {queue_ff[rd_ptr_ff].line_index, queue_ff[rd_ptr_ff].number_value};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].status;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

   // Checks on the queue and the token state.
   `RNTP_ASSERT(a_queue_count, clock, reset, count_ff <= COUNT_BITS'(QUEUE_DEPTH), "queue overrun")
   `RNTP_ASSERT_NEXT(a_eoi_result, clock, reset, fire && in_eoi_ff, rsp_tvalid, "end marker lost")
   `RNTP_ASSERT(a_sign_acc, clock, reset, phase_ff != PHASE_SIGN || acc_ff == '0, "value in sign")
   `RNTP_ASSERT(a_comment_scan, clock, reset, !in_comment_ff || phase_ff == PHASE_SCAN, "stray comment")

endmodule
